[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/i2cbe_pkg.sv]
`default_nettype none

package i2cbe_pkg;

    localparam logic [2:0] MODE_START    = 3'd0;
    localparam logic [2:0] MODE_STOP     = 3'd1;
    localparam logic [2:0] MODE_WRITE    = 3'd2;
    localparam logic [2:0] MODE_READ_ACK = 3'd3;
    localparam logic [2:0] MODE_READ_NAK = 3'd4;

    localparam logic [7:0] ACK_POLL_TICKS  = 8'd10;
    localparam logic [7:0] DELAY_RESET     = 8'd5;
    localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST0, PH_ST1, PH_ST2, PH_SP0, PH_SP1, PH_SP2,
        PH_WR0, PH_WRB, PH_WRH, PH_WRL, PH_WA0, PH_WA1, PH_WA2, PH_WA3, PH_WA4,
        PH_RD0, PH_RD1, PH_RD2, PH_RD3, PH_RD4,
        PH_RK0, PH_RK1, PH_RK2, PH_RK3, PH_RN1, PH_RN2
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] bit_count;
        logic [7:0] shift;
        logic [7:0] delay;
        logic [2:0] mode;
        logic       ack;
        logic       scl;
        logic       sda;
        logic       drv;
        logic [7:0] read_data;
    } state_t;

endpackage

`default_nettype wire

[design/i2cbe_step.sv]
`default_nettype none

module i2cbe_step (
    input  i2cbe_pkg::state_t cur,
    input  logic [7:0]        phase_delay,
    input  logic              cmd_valid,
    input  logic [2:0]        mode,
    input  logic [7:0]        write_byte,
    input  logic              sda_in,
    output i2cbe_pkg::state_t nxt,
    output logic              done
);
    import i2cbe_pkg::*;

    function automatic phase_t next_phase(input phase_t p, input logic [3:0] bc,
                                          input logic [2:0] m);
        phase_t n;
        begin
            unique case (p)
                PH_ST0:  n = PH_ST1;
                PH_ST1:  n = PH_ST2;
                PH_SP0:  n = PH_SP1;
                PH_SP1:  n = PH_SP2;
                PH_WR0:  n = PH_WRB;
                PH_WRB:  n = PH_WRH;
                PH_WRH:  n = PH_WRL;
                PH_WRL:  n = (bc >= BITS_PER_BYTE) ? PH_WA0 : PH_WRB;
                PH_WA0:  n = PH_WA1;
                PH_WA1:  n = PH_WA2;
                PH_WA2:  n = PH_WA3;
                PH_WA3:  n = PH_WA4;
                PH_RD0:  n = PH_RD1;
                PH_RD1:  n = PH_RD2;
                PH_RD2:  n = PH_RD3;
                PH_RD3:  n = PH_RD4;
                PH_RD4:
                begin
                    if (bc < BITS_PER_BYTE)
                        n = PH_RD1;
                    else
                        n = (m == MODE_READ_ACK) ? PH_RK0 : PH_RN1;
                end
                PH_RK0:  n = PH_RK1;
                PH_RK1:  n = PH_RK2;
                PH_RK2:  n = PH_RK3;
                PH_RN1:  n = PH_RN2;
                default: n = PH_IDLE;
            endcase
            return n;
        end
    endfunction

    logic [7:0] long_wait;
    phase_t     tgt;
    logic       do_enter;

    assign long_wait = (phase_delay == 8'd0) ? 8'd1 : phase_delay;

    always_comb
    begin
        nxt      = cur;
        done     = 1'b0;
        tgt      = PH_IDLE;
        do_enter = 1'b0;

        if (cur.phase == PH_IDLE)
        begin
            if (cmd_valid && mode <= MODE_READ_NAK)
            begin
                nxt.mode      = mode;
                nxt.bit_count = 4'd0;
                nxt.ack       = 1'b0;
                nxt.shift     = (mode == MODE_WRITE) ? write_byte : 8'd0;
                do_enter      = 1'b1;
                unique case (mode)
                    MODE_START: tgt = PH_ST0;
                    MODE_STOP:  tgt = PH_SP0;
                    MODE_WRITE: tgt = PH_WR0;
                    default:    tgt = PH_RD0;
                endcase
            end
        end
        else if (cur.delay > 8'd1)
        begin
            nxt.delay = cur.delay - 8'd1;
        end
        else
        begin
            tgt = next_phase(cur.phase, cur.bit_count, cur.mode);
            if (tgt == PH_IDLE)
            begin
                if (cur.phase == PH_RN2)
                begin
                    nxt.scl = 1'b0;
                    nxt.sda = 1'b0;
                end
                nxt.phase = PH_IDLE;
                nxt.delay = 8'd0;
                done      = 1'b1;
            end
            else
            begin
                do_enter = 1'b1;
            end
        end

        if (do_enter)
        begin
            nxt.phase = tgt;
            nxt.delay = long_wait;
            unique case (tgt)
                PH_ST0:
                begin
                    nxt.drv = 1'b1; nxt.sda = 1'b1; nxt.scl = 1'b1; nxt.delay = 8'd2;
                end
                PH_ST1: nxt.sda = 1'b0;
                PH_ST2: nxt.scl = 1'b0;
                PH_SP0:
                begin
                    nxt.drv = 1'b1; nxt.sda = 1'b0;
                end
                PH_SP1: nxt.scl = 1'b1;
                PH_SP2: nxt.sda = 1'b1;
                PH_WR0: nxt.scl = 1'b0;
                PH_WRB: nxt.sda = nxt.shift[7];
                PH_WRH: nxt.scl = 1'b1;
                PH_WRL:
                begin
                    nxt.scl       = 1'b0;
                    nxt.delay     = 8'd1;
                    nxt.shift     = {nxt.shift[6:0], 1'b0};
                    nxt.bit_count = nxt.bit_count + 4'd1;
                end
                PH_WA0: nxt.delay = 8'd1;
                PH_WA1: nxt.drv = 1'b0;
                PH_WA2:
                begin
                    nxt.scl = 1'b1; nxt.delay = ACK_POLL_TICKS;
                end
                PH_WA3: nxt.delay = long_wait;
                PH_WA4:
                begin
                    nxt.scl = 1'b0; nxt.drv = 1'b1; nxt.delay = 8'd1;
                end
                PH_RD0:
                begin
                    nxt.drv = 1'b0; nxt.delay = 8'd1;
                end
                PH_RD1: nxt.delay = 8'd4;
                PH_RD2:
                begin
                    nxt.scl = 1'b1; nxt.delay = 8'd3;
                end
                PH_RD3:
                begin
                    nxt.shift = {nxt.shift[6:0], sda_in};
                    nxt.delay = 8'd2;
                end
                PH_RD4:
                begin
                    nxt.scl       = 1'b0;
                    nxt.delay     = 8'd1;
                    nxt.bit_count = nxt.bit_count + 4'd1;
                end
                PH_RK0:
                begin
                    nxt.drv = 1'b1; nxt.read_data = nxt.shift; nxt.delay = 8'd1;
                end
                PH_RK1: nxt.sda = 1'b0;
                PH_RK2: nxt.scl = 1'b1;
                PH_RK3:
                begin
                    nxt.scl = 1'b0; nxt.delay = 8'd1;
                end
                PH_RN1:
                begin
                    nxt.drv = 1'b1; nxt.sda = 1'b1; nxt.read_data = nxt.shift;
                end
                PH_RN2: nxt.scl = 1'b1;
                default: nxt.delay = 8'd1;
            endcase
        end

        // ack poll ends early on first low SDA
        if (cur.phase != PH_IDLE && nxt.phase == PH_WA2 && !sda_in)
        begin
            nxt.ack   = 1'b1;
            nxt.delay = 8'd1;
        end
    end

endmodule

`default_nettype wire

[design/i2c_master_byte_engine_top.sv]
// Bit-level I2C master, one bus tick per input transfer.
// A tick's registered result appears on the master side the cycle after acceptance.
// Throughput: one tick per cycle; the next-state logic is a single registered pass.
// Input is stalled only while the result register is full and not being taken.
// Reset (rst_n low, async): bus idle, SCL/SDA high and driven, delay register = 5.
`default_nettype none

module i2c_master_byte_engine_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,    // phase_delay_ticks
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // write_byte[7:0], sda_in[8], zero[15:9]
    input  logic [3:0]  s_axis_tuser,   // cmd_valid[0], mode[3:1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // scl_level[0], sda_level[1], sda_drive[2],
                                        // busy_res[3], done_res[4], read_byte[12:5],
                                        // ack_received[13], zero[15:14]
);
    import i2cbe_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic       done_next;
    logic [7:0] delay_cfg_reg;
    logic       out_valid_reg;
    logic [15:0] out_data_reg;
    logic       s_xfer;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    i2cbe_step u_step (
        .cur         (state_reg),
        .phase_delay (delay_cfg_reg),
        .cmd_valid   (s_axis_tuser[0]),
        .mode        (s_axis_tuser[3:1]),
        .write_byte  (s_axis_tdata[7:0]),
        .sda_in      (s_axis_tdata[8]),
        .nxt         (state_next),
        .done        (done_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_cfg_reg <= DELAY_RESET;
        end
        else if (cfg_wr_en)
        begin
            delay_cfg_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: PH_IDLE, bit_count: 4'd0, shift: 8'd0, delay: 8'd0,
                           mode: 3'd0, ack: 1'b0, scl: 1'b1, sda: 1'b1, drv: 1'b1,
                           read_data: 8'd0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_xfer)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            out_data_reg <= {2'b00, state_next.ack, state_next.read_data, done_next,
                             (state_next.phase != PH_IDLE), state_next.drv,
                             state_next.sda, state_next.scl};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

[design/i2cbe_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module i2cbe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    `ASSERT_CLK(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    `ASSERT_CLK(a_in_gives_out, clk, rst_n, s_axis_tvalid && s_axis_tready |=> m_axis_tvalid, "accepted tick produced no result")

    `ASSERT_CLK(a_ready_when_empty, clk, rst_n, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty result register")

    `ASSERT_CLK(a_done_not_busy, clk, rst_n, m_axis_tvalid |-> !(m_axis_tdata[4] && m_axis_tdata[3]), "done and busy together")

endmodule

bind i2c_master_byte_engine_top i2cbe_checker u_i2cbe_checker (.*);

`default_nettype wire
